// ===== design/cal_pkg.sv =====
// cal_pkg: shared types and constants for the cursor array list
// operation codes, cell shift commands and list status flags
// no dependencies
package cal_pkg;

   localparam int DataWidth  = 32;
   localparam int FieldWidth = 7;
   localparam logic [FieldWidth-1:0] CapacityReset = 7'd64;

   typedef enum logic [2:0] {
      OP_INS_BEFORE = 3'd0,
      OP_INS_AFTER  = 3'd1,
      OP_REMOVE     = 3'd2,
      OP_BEGIN      = 3'd3,
      OP_END        = 3'd4,
      OP_NEXT       = 3'd5,
      OP_PRIOR      = 3'd6,
      OP_CLEAR      = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      SHIFT_HOLD   = 2'd0,
      SHIFT_INSERT = 2'd1,
      SHIFT_REMOVE = 2'd2
   } shift_mode_type;

   typedef struct packed {
      shift_mode_type               mode;
      logic signed [DataWidth-1:0]  value;
   } shift_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } list_status_type;

endpackage

// ===== design/cal_ifs.sv =====
// cal_ifs: valid/ready channel interfaces for requests and responses
// depends on cal_pkg
interface cal_req_if;
   import cal_pkg::*;
   logic                        valid;
   logic                        ready;
   op_type                      operation;
   logic signed [DataWidth-1:0] value;

   modport source(output valid, operation, value, input ready);
   modport sink(input valid, operation, value, output ready);
endinterface

interface cal_rsp_if;
   import cal_pkg::*;
   logic                         valid;
   logic                         ready;
   logic                         success;
   logic signed [DataWidth-1:0]  cursor_value;
   logic signed [FieldWidth-1:0] cursor_position;
   logic [FieldWidth-1:0]        element_count;
   logic                         list_empty;
   logic                         list_full;

   modport source(output valid, success, cursor_value, cursor_position, element_count,
                  list_empty, list_full, input ready);
   modport sink(input valid, success, cursor_value, cursor_position, element_count,
                list_empty, list_full, output ready);
endinterface

// ===== design/cal_cell.sv =====
// cal_cell: one entry of the list, shifts with its neighbors on insert and remove
// and drives its value onto the read bus when it sits under the cursor
// depends on cal_pkg
module cal_cell #(
   parameter int DEPTH = 64,
   parameter int INDEX = 0
) (
   input  logic                                  clock,
   input  cal_pkg::shift_cmd_type                cmd,
   input  logic [$clog2(DEPTH)-1:0]              shift_pos,
   input  logic signed [cal_pkg::DataWidth-1:0]  left_data,
   input  logic signed [cal_pkg::DataWidth-1:0]  right_data,
   input  logic [$clog2(DEPTH)-1:0]              cursor,
   input  logic                                  empty,
   output logic signed [cal_pkg::DataWidth-1:0]  data,
   output logic signed [cal_pkg::DataWidth-1:0]  tap
);
   import cal_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam logic [IW-1:0] Slot = IW'(INDEX);

   logic signed [DataWidth-1:0] data_ff;
   logic signed [DataWidth-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (cmd.mode)
         SHIFT_INSERT: begin
            if (Slot == shift_pos) begin
               data_in = cmd.value;
            end else if (Slot > shift_pos) begin
               data_in = left_data;
            end
         end
         SHIFT_REMOVE: begin
            if (Slot >= shift_pos) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign tap  = (!empty && cursor == Slot) ? data_ff : '0;

endmodule

// ===== design/cal_ctrl.sv =====
// cal_ctrl: count and cursor registers, request decode and shift command for the cells
// depends on cal_pkg
module cal_ctrl #(
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   accept,
   input  cal_pkg::op_type                        operation,
   input  logic signed [cal_pkg::DataWidth-1:0]   value,
   input  logic [cal_pkg::FieldWidth-1:0]         capacity,
   output logic                                   success,
   output logic [$clog2(DEPTH)-1:0]               cursor,
   output logic [$clog2(DEPTH+1)-1:0]             count,
   output cal_pkg::list_status_type               status,
   output cal_pkg::shift_cmd_type                 cmd,
   output logic [$clog2(DEPTH)-1:0]               shift_pos
);
   import cal_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int MW = (CW > FieldWidth) ? CW : FieldWidth;

   logic [IW-1:0] cursor_ff, cursor_in;
   logic [CW-1:0] count_ff, count_in;
   logic          empty, full, at_last, at_first;
   logic          ok;
   shift_cmd_type cmd_w;
   logic [IW-1:0] pos_w;

   assign empty    = (count_ff == '0);
   assign full     = (MW'(count_ff) >= MW'(capacity)) || (MW'(count_ff) >= MW'(DEPTH));
   assign at_last  = ((CW'(cursor_ff) + CW'(1)) == count_ff);
   assign at_first = (cursor_ff == '0);

   always_comb begin
      count_in    = count_ff;
      cursor_in   = cursor_ff;
      ok          = 1'b0;
      cmd_w.mode  = SHIFT_HOLD;
      cmd_w.value = value;
      pos_w       = cursor_ff;
      unique case (operation)
         OP_INS_BEFORE, OP_INS_AFTER: begin
            if (!full) begin
               ok         = 1'b1;
               count_in   = count_ff + CW'(1);
               cmd_w.mode = SHIFT_INSERT;
               if (empty) begin
                  pos_w     = '0;
                  cursor_in = '0;
               end else if (operation == OP_INS_AFTER) begin
                  pos_w     = cursor_ff + IW'(1);
                  cursor_in = cursor_ff + IW'(1);
               end
            end
         end
         OP_REMOVE: begin
            if (!empty) begin
               ok       = 1'b1;
               count_in = count_ff - CW'(1);
               // removing the tail element wraps the cursor to the front
               if (at_last) begin
                  cursor_in = '0;
               end else begin
                  cmd_w.mode = SHIFT_REMOVE;
               end
            end
         end
         OP_BEGIN: begin
            if (!empty && !at_first) begin
               ok        = 1'b1;
               cursor_in = '0;
            end
         end
         OP_END: begin
            if (!empty && !at_last) begin
               ok        = 1'b1;
               cursor_in = IW'(count_ff - CW'(1));
            end
         end
         OP_NEXT: begin
            if (!empty && !at_last) begin
               ok        = 1'b1;
               cursor_in = cursor_ff + IW'(1);
            end
         end
         OP_PRIOR: begin
            if (!empty && !at_first) begin
               ok        = 1'b1;
               cursor_in = cursor_ff - IW'(1);
            end
         end
         OP_CLEAR: begin
            ok        = 1'b1;
            count_in  = '0;
            cursor_in = '0;
         end
      endcase
      if (!accept) begin
         cmd_w.mode = SHIFT_HOLD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cursor_ff <= '0;
      end else if (accept) begin
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
      end
   end

   assign success      = ok;
   assign cursor       = cursor_ff;
   assign count        = count_ff;
   assign status.empty = empty;
   assign status.full  = full;
   assign cmd          = cmd_w;
   assign shift_pos    = pos_w;

endmodule

// ===== design/cursor_array_list.sv =====
// cursor_array_list: ordered list of signed 32-bit values with a count and a cursor
// depends on cal_pkg, cal_ifs, cal_ctrl and cal_cell
//
// Usage:
//   req_ch carries one request (operation, value) per valid/ready handshake;
//   rsp_ch returns exactly one response per request, in order: success, the
//   value and position under the cursor, the count, and empty/full flags.
//   csr_write_en/csr_write_data set the capacity limit (reset 64, clipped to
//   DEPTH); write it only while no request is in flight.
// Timing:
//   a request accepted at a clock edge updates count, cursor and cells at that
//   edge. One request per cycle is sustained while rsp_ch.ready stays high: the
//   row of DEPTH cells shifts all entries in the cycle the request is taken,
//   and the cursor entry is read into the response register as the stage moves.
// Reset:
//   the list is empty (count 0, reported position -1) and the capacity is 64. Entry
//   contents are not cleared; an entry is never read before it is written.
// Stalls:
//   while rsp_ch.ready is low the response register holds, one more request
//   can be taken into the read stage, and req_ch.ready then drops until the
//   response drains.
module cursor_array_list #(
   parameter int DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   cal_req_if.sink                           req_ch,
   cal_rsp_if.source                         rsp_ch,
   input  logic                              csr_write_en,
   input  logic [cal_pkg::FieldWidth-1:0]    csr_write_data
);
   import cal_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [FieldWidth-1:0]        capacity_ff;
   logic                         accept;
   logic                         success_w;
   logic [IW-1:0]                cursor_w;
   logic [CW-1:0]                count_w;
   list_status_type              status_w;
   shift_cmd_type                cmd_w;
   logic [IW-1:0]                pos_w;
   logic signed [DataWidth-1:0]  cell_data [DEPTH];
   logic signed [DataWidth-1:0]  cell_tap [DEPTH];
   logic signed [DataWidth-1:0]  read_value;

   logic                         stage_ff, stage_in;
   logic                         stage_ok_ff;
   logic                         stage_move;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_success_ff;
   logic signed [DataWidth-1:0]  rsp_value_ff;
   logic signed [FieldWidth-1:0] rsp_position_ff;
   logic [FieldWidth-1:0]        rsp_count_ff;
   logic                         rsp_empty_ff;
   logic                         rsp_full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CapacityReset;
      end else if (csr_write_en) begin
         capacity_ff <= csr_write_data;
      end
   end

   assign stage_move   = stage_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !stage_ff || stage_move;
   assign accept       = req_ch.valid && req_ch.ready;

   cal_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .operation (req_ch.operation),
      .value     (req_ch.value),
      .capacity  (capacity_ff),
      .success   (success_w),
      .cursor    (cursor_w),
      .count     (count_w),
      .status    (status_w),
      .cmd       (cmd_w),
      .shift_pos (pos_w)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DataWidth-1:0] left_w, right_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_left
         assign left_w = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_w = cell_data[i];
      end else begin : g_mid_right
         assign right_w = cell_data[i+1];
      end
      cal_cell #(.DEPTH(DEPTH), .INDEX(i)) u_cell (
         .clock      (clock),
         .cmd        (cmd_w),
         .shift_pos  (pos_w),
         .left_data  (left_w),
         .right_data (right_w),
         .cursor     (cursor_w),
         .empty      (status_w.empty),
         .data       (cell_data[i]),
         .tap        (cell_tap[i])
      );
   end

   // at most one cell drives a nonzero tap
   always_comb begin
      read_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         read_value = read_value | cell_tap[i];
      end
   end

   always_comb begin
      stage_in = stage_ff;
      if (accept) begin
         stage_in = 1'b1;
      end else if (stage_move) begin
         stage_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ok_ff <= success_w;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (stage_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_move) begin
         rsp_success_ff  <= stage_ok_ff;
         rsp_value_ff    <= read_value;
         rsp_position_ff <= status_w.empty ? '1 : FieldWidth'(cursor_w);
         rsp_count_ff    <= FieldWidth'(count_w);
         rsp_empty_ff    <= status_w.empty;
         rsp_full_ff     <= status_w.full;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.success         = rsp_success_ff;
   assign rsp_ch.cursor_value    = rsp_value_ff;
   assign rsp_ch.cursor_position = rsp_position_ff;
   assign rsp_ch.element_count   = rsp_count_ff;
   assign rsp_ch.list_empty      = rsp_empty_ff;
   assign rsp_ch.list_full       = rsp_full_ff;

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.operation == OP_CLEAR |=> count_w == '0)
      else $error("clear request did not empty the list");

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      count_w != '0 |-> CW'(cursor_w) < count_w)
      else $error("cursor points past the last element");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      stage_ff && !stage_move |=> stage_ff && $stable(stage_ok_ff))
      else $error("read stage lost a request while the response stalled");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      accept && success_w && (req_ch.operation == OP_INS_BEFORE
         || req_ch.operation == OP_INS_AFTER) |=> count_w == $past(count_w) + CW'(1))
      else $error("successful insert did not grow the count");

endmodule

// ===== test/cal_list_checker.sv =====
`timescale 1ns / 1ps
// cal_list_checker: watches the request, response and csr ports of the cursor array list,
// keeps its own copy of the list to predict each response, and counts mismatches
// depends on cal_pkg and cal_ifs
module cal_list_checker (
   input  logic                           clock,
   input  logic                           reset,
   cal_req_if                             req_mon,
   cal_rsp_if                             rsp_mon,
   input  logic                           csr_write_en,
   input  logic [cal_pkg::FieldWidth-1:0] csr_write_data,
   output int                             mismatch_count,
   output int                             awaiting
);
   import cal_pkg::*;

   localparam int Slots = 64;

   typedef struct {
      logic                         success;
      logic signed [DataWidth-1:0]  cursor_value;
      logic signed [FieldWidth-1:0] cursor_position;
      logic [FieldWidth-1:0]        element_count;
      logic                         list_empty;
      logic                         list_full;
   } list_view_type;

   logic signed [DataWidth-1:0] slots [Slots];
   int                          held;
   int                          cursor_at;
   logic [FieldWidth-1:0]       capacity;
   list_view_type               pending_views [$];
   int                          responses_seen;

   initial begin
      foreach (slots[i]) slots[i] = '0;
      held           = 0;
      cursor_at      = -1;
      capacity       = CapacityReset;
      mismatch_count = 0;
      awaiting       = 0;
      responses_seen = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at response %0d: %s", responses_seen, msg);
      mismatch_count++;
   endtask

   // applies one request to the shadow list and returns the response it should give
   function automatic list_view_type apply_list_op(input op_type op,
                                                   input logic signed [DataWidth-1:0] v);
      list_view_type view;
      int            limit;
      logic          ok;
      limit = (capacity > Slots) ? Slots : int'(capacity);
      ok    = 1'b0;
      case (op)
         OP_INS_BEFORE, OP_INS_AFTER: begin
            if (held < limit) begin
               ok = 1'b1;
               if (held == 0) begin
                  slots[0]  = v;
                  cursor_at = 0;
               end else if (op == OP_INS_AFTER) begin
                  for (int i = held; i > cursor_at + 1; i--) slots[i] = slots[i-1];
                  cursor_at++;
                  slots[cursor_at] = v;
               end else begin
                  for (int i = held; i > cursor_at; i--) slots[i] = slots[i-1];
                  slots[cursor_at] = v;
               end
               held++;
            end
         end
         OP_REMOVE: begin
            if (held > 0) begin
               ok = 1'b1;
               if (cursor_at == held - 1) begin
                  held--;
                  cursor_at = (held > 0) ? 0 : -1;
               end else begin
                  for (int i = cursor_at; i < held - 1; i++) slots[i] = slots[i+1];
                  held--;
               end
            end
         end
         OP_BEGIN: begin
            if (held > 0 && cursor_at != 0) begin
               cursor_at = 0;
               ok        = 1'b1;
            end
         end
         OP_END: begin
            if (held > 0 && cursor_at != held - 1) begin
               cursor_at = held - 1;
               ok        = 1'b1;
            end
         end
         OP_NEXT: begin
            if (held > 0 && cursor_at != held - 1) begin
               cursor_at++;
               ok = 1'b1;
            end
         end
         OP_PRIOR: begin
            if (held > 0 && cursor_at != 0) begin
               cursor_at--;
               ok = 1'b1;
            end
         end
         default: begin
            held      = 0;
            cursor_at = -1;
            ok        = 1'b1;
         end
      endcase
      view.success         = ok;
      view.cursor_value    = (held > 0) ? slots[cursor_at] : '0;
      view.cursor_position = cursor_at[FieldWidth-1:0];
      view.element_count   = held[FieldWidth-1:0];
      view.list_empty      = (held == 0);
      view.list_full       = (held >= limit);
      return view;
   endfunction

   always @(posedge clock) begin
      list_view_type want;
      if (reset) begin
         held      = 0;
         cursor_at = -1;
         capacity  = CapacityReset;
         pending_views.delete();
      end else begin
         if (csr_write_en) capacity = csr_write_data;
         if (rsp_mon.valid && rsp_mon.ready) begin
            responses_seen++;
            if (pending_views.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = pending_views.pop_front();
               if (rsp_mon.success !== want.success)
                  report_mismatch($sformatf("success %b, want %b",
                                            rsp_mon.success, want.success));
               if (rsp_mon.cursor_value !== want.cursor_value)
                  report_mismatch($sformatf("cursor_value %h, want %h",
                                            rsp_mon.cursor_value, want.cursor_value));
               if (rsp_mon.cursor_position !== want.cursor_position)
                  report_mismatch($sformatf("cursor_position %h, want %h",
                                            rsp_mon.cursor_position, want.cursor_position));
               if (rsp_mon.element_count !== want.element_count)
                  report_mismatch($sformatf("element_count %0d, want %0d",
                                            rsp_mon.element_count, want.element_count));
               if (rsp_mon.list_empty !== want.list_empty)
                  report_mismatch($sformatf("list_empty %b, want %b",
                                            rsp_mon.list_empty, want.list_empty));
               if (rsp_mon.list_full !== want.list_full)
                  report_mismatch($sformatf("list_full %b, want %b",
                                            rsp_mon.list_full, want.list_full));
            end
         end
         if (req_mon.valid && req_mon.ready)
            pending_views.push_back(apply_list_op(req_mon.operation, req_mon.value));
      end
      awaiting = pending_views.size();
   end

endmodule

// ===== test/tb_cursor_array_list.sv =====
`timescale 1ns / 1ps
// tb_cursor_array_list: request stimulus, response draining and verdict for the list
// depends on cal_pkg, cal_ifs, cursor_array_list and cal_list_checker
module tb_cursor_array_list;
   import cal_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   logic [FieldWidth-1:0] csr_write_data;
   int                    mismatch_count;
   int                    awaiting;
   int                    requests_sent;

   cal_req_if req_if();
   cal_rsp_if rsp_if();

   cursor_array_list DUT (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_if),
      .rsp_ch         (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   cal_list_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .mismatch_count (mismatch_count),
      .awaiting       (awaiting)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("status: fail");
      $finish;
   end

   // one request: optional idle gap, then hold valid until the handshake
   task automatic send_request(input op_type op, input logic signed [DataWidth-1:0] v);
      int gap;
      gap = ((requests_sent % 64) < 16) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.operation <= op;
      req_if.value     <= v;
      do @(posedge clock); while (!req_if.ready);
      requests_sent++;
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (awaiting != 0) @(negedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [FieldWidth-1:0] cap);
      wait_drained();
      csr_write_en   <= 1'b1;
      csr_write_data <= cap;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   function automatic logic signed [DataWidth-1:0] pick_value();
      case ($urandom_range(0, 19))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic op_type pick_op(input int ins_pct, input int rem_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < ins_pct) return $urandom_range(0, 1) ? OP_INS_AFTER : OP_INS_BEFORE;
      if (r < ins_pct + rem_pct) return OP_REMOVE;
      if (r < 98) return op_type'($urandom_range(int'(OP_BEGIN), int'(OP_PRIOR)));
      return OP_CLEAR;
   endfunction

   task automatic run_random(input int n, input int ins_pct, input int rem_pct);
      repeat (n) send_request(pick_op(ins_pct, rem_pct), pick_value());
   endtask

   // response side: random stalls, a couple of long hold-offs to back up the block
   initial begin
      int stall;
      int taken;
      taken        = 0;
      rsp_if.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = ((taken % 48) < 12) ? 0 : $urandom_range(0, 18);
         if (taken == 40 || taken == 300) stall = 90;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         taken++;
      end
   end

   initial begin
      int guard;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.operation = OP_CLEAR;
      req_if.value     = '0;
      csr_write_en     = 1'b0;
      csr_write_data   = '0;
      requests_sent    = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list: clear succeeds, everything else is refused
      send_request(OP_CLEAR, '0);
      send_request(OP_REMOVE, '0);
      send_request(OP_BEGIN, '0);
      send_request(OP_END, '0);
      send_request(OP_NEXT, '0);
      send_request(OP_PRIOR, '0);
      // first insert, then insert after, then moves with nothing to do
      send_request(OP_INS_BEFORE, 32'sh7FFF_FFFF);
      send_request(OP_INS_AFTER, 32'sh8000_0000);
      send_request(OP_NEXT, '0);
      send_request(OP_END, '0);
      send_request(OP_INS_BEFORE, -32'sd1);
      send_request(OP_BEGIN, '0);
      send_request(OP_BEGIN, '0);
      send_request(OP_PRIOR, '0);
      send_request(OP_INS_AFTER, '0);
      send_request(OP_NEXT, '0);
      send_request(OP_PRIOR, '0);
      send_request(OP_END, '0);
      // remove at the tail wraps the cursor to the head, then remove at the head
      send_request(OP_REMOVE, '0);
      send_request(OP_REMOVE, '0);
      send_request(OP_INS_BEFORE, 32'sh5555_AAAA);
      send_request(OP_INS_AFTER, 32'shAAAA_5555);
      send_request(OP_CLEAR, '0);

      // capacity of one: second insert refused on a full list
      write_capacity(7'd1);
      send_request(OP_INS_AFTER, 32'sh1234_5678);
      send_request(OP_INS_AFTER, 32'sh0F0F_0F0F);
      send_request(OP_INS_BEFORE, 32'shF0F0_F0F0);
      send_request(OP_REMOVE, '0);
      send_request(OP_CLEAR, '0);

      // capacity zero: every insert refused
      write_capacity(7'd0);
      send_request(OP_INS_BEFORE, 32'sh0000_0001);
      send_request(OP_INS_AFTER, 32'sh0000_0002);
      send_request(OP_REMOVE, '0);

      // above the store depth: saturates, fill the whole store
      write_capacity(7'd127);
      run_random(130, 65, 8);

      // capacity dropped below the current count
      write_capacity(7'd5);
      run_random(30, 40, 30);

      write_capacity(7'd64);
      run_random(140, 50, 20);

      write_capacity(7'($urandom_range(1, 8)));
      run_random(80, 45, 25);

      write_capacity(7'($urandom_range(0, 127)));
      run_random(70, 50, 20);

      req_if.valid <= 1'b0;
      guard = 0;
      @(negedge clock);
      while (awaiting != 0 && guard < 5000) begin
         @(negedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && awaiting == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
